// ===== rtl/core/rcms_pkg.sv =====
// Types and codes shared by the radio carrier state machine.
// No dependencies; imported by every module of the block.
`default_nettype none

package rcms_pkg;

   // Event codes carried in req_type
   typedef enum logic [2:0] {
      EV_SW_ACT_REP  = 3'd0,
      EV_STATE_REP   = 3'd1,
      EV_ATTR_ACK    = 3'd2,
      EV_OPSTART_ACK = 3'd3,
      EV_OPSTART_NAK = 3'd4,
      EV_FORCE_LOCK  = 3'd5,
      EV_LINK_DOWN   = 3'd6
   } rcms_event_type;

   // Operational state of the carrier
   typedef enum logic [1:0] {
      ST_NOT_INSTALLED = 2'd0,
      ST_DEPENDENCY    = 2'd1,
      ST_OFFLINE       = 2'd2,
      ST_ENABLED       = 2'd3
   } rcms_mode_type;

   // Administrative command codes
   localparam logic [1:0] ADM_NONE   = 2'd0;
   localparam logic [1:0] ADM_UNLOCK = 2'd1;
   localparam logic [1:0] ADM_LOCK   = 2'd2;

   // Reported availability codes
   localparam logic [2:0] AV_NOT_INSTALLED = 3'd0;
   localparam logic [2:0] AV_POWER_OFF     = 3'd1;
   localparam logic [2:0] AV_DEPENDENCY    = 3'd2;
   localparam logic [2:0] AV_OFFLINE       = 3'd3;
   localparam logic [2:0] AV_OK            = 3'd4;

   typedef struct packed {
      logic [2:0] req_type;
      logic       rep_operational;
      logic [2:0] rep_availability;
      logic       rep_admin_unlocked;
      logic       stored_admin_unlocked;
      logic       lock_request;
   } rcms_req_type;

   typedef struct packed {
      logic [1:0] carrier_state;
      logic       send_set_attr;
      logic [1:0] adm_command;
      logic       send_opstart;
      logic       event_rejected;
   } rcms_rsp_type;

   typedef struct packed {
      rcms_mode_type mode;
      logic          attr_sent;
      logic          attr_acked;
      logic          unlock_sent;
      logic          opstart_pending;
      logic          forced_lock;
   } rcms_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/rcms_event_logic.sv =====
// Next-state and command logic for one event against the current carrier state.
// Depends on rcms_pkg.
`default_nettype none

module rcms_event_logic (
   input  rcms_pkg::rcms_req_type   req,
   input  rcms_pkg::rcms_state_type cur,
   output rcms_pkg::rcms_state_type nxt,
   output rcms_pkg::rcms_rsp_type   rsp
);
   import rcms_pkg::*;

   rcms_event_type ev;
   rcms_mode_type  tgt;
   logic           tgt_move;
   logic           run_pass;
   logic           pass_admin;
   logic           pass_allow_op;
   logic           set_attr;
   logic [1:0]     adm;
   logic           opstart;
   logic           rejected;
   rcms_state_type mid;

   assign ev = rcms_event_type'(req.req_type);

   // Target state of a state report
   always_comb begin
      tgt      = cur.mode;
      tgt_move = 1'b0;
      if (req.rep_operational) begin
         tgt      = ST_ENABLED;
         tgt_move = (cur.mode != ST_ENABLED);
      end else begin
         unique case (req.rep_availability)
            AV_NOT_INSTALLED, AV_POWER_OFF: begin
               tgt      = ST_NOT_INSTALLED;
               tgt_move = 1'b1;
            end
            AV_DEPENDENCY: begin
               tgt      = ST_DEPENDENCY;
               tgt_move = 1'b1;
            end
            AV_OFFLINE, AV_OK: begin
               tgt      = ST_OFFLINE;
               tgt_move = 1'b1;
            end
            default: begin
               tgt      = cur.mode;
               tgt_move = 1'b0;
            end
         endcase
      end
   end

   // Event decode: state moves, rejections, forced-lock commands and which configuration pass runs
   always_comb begin
      mid           = cur;
      adm           = ADM_NONE;
      rejected      = 1'b0;
      run_pass      = 1'b0;
      pass_admin    = req.stored_admin_unlocked;
      pass_allow_op = 1'b0;
      unique case (ev) inside
         EV_SW_ACT_REP: begin
            rejected = (cur.mode != ST_NOT_INSTALLED);
         end
         EV_STATE_REP: begin
            if (tgt_move) begin
               if (tgt == cur.mode) begin
                  // re-report of current state: dependency or offline runs a pass with reported admin bit
                  if (tgt == ST_DEPENDENCY || tgt == ST_OFFLINE) begin
                     run_pass      = 1'b1;
                     pass_admin    = req.rep_admin_unlocked;
                     pass_allow_op = (tgt == ST_OFFLINE);
                  end
               end else begin
                  mid.mode = tgt;
                  if (tgt == ST_NOT_INSTALLED || tgt == ST_ENABLED) begin
                     mid.attr_sent       = 1'b0;
                     mid.attr_acked      = 1'b0;
                     mid.unlock_sent     = 1'b0;
                     mid.opstart_pending = 1'b0;
                  end else begin
                     run_pass      = 1'b1;
                     pass_allow_op = (tgt == ST_OFFLINE);
                  end
               end
            end
         end
         EV_ATTR_ACK: begin
            if (cur.mode == ST_DEPENDENCY || cur.mode == ST_OFFLINE) begin
               mid.attr_acked = 1'b1;
               mid.attr_sent  = 1'b0;
               run_pass       = 1'b1;
               pass_allow_op  = (cur.mode == ST_OFFLINE);
            end else begin
               rejected = 1'b1;
            end
         end
         EV_OPSTART_ACK, EV_OPSTART_NAK: begin
            mid.opstart_pending = 1'b0;
         end
         EV_FORCE_LOCK: begin
            mid.forced_lock = req.lock_request;
            adm             = req.lock_request ? ADM_LOCK : ADM_UNLOCK;
         end
         EV_LINK_DOWN: begin
            if (cur.mode != ST_NOT_INSTALLED) begin
               mid.mode            = ST_NOT_INSTALLED;
               mid.attr_sent       = 1'b0;
               mid.attr_acked      = 1'b0;
               mid.unlock_sent     = 1'b0;
               mid.opstart_pending = 1'b0;
            end
         end
         default: begin
            rejected = 1'b1;
         end
      endcase
   end

   // Configuration pass on the updated flags
   always_comb begin
      nxt      = mid;
      set_attr = 1'b0;
      opstart  = 1'b0;
      rsp.adm_command = adm;
      if (run_pass) begin
         if (!mid.attr_sent && !mid.attr_acked) begin
            nxt.attr_sent = 1'b1;
            set_attr      = 1'b1;
         end
         if (!mid.forced_lock && !pass_admin && !mid.unlock_sent) begin
            nxt.unlock_sent = 1'b1;
            rsp.adm_command = ADM_UNLOCK;
         end
         if (pass_allow_op && pass_admin && mid.attr_acked && !mid.opstart_pending) begin
            nxt.opstart_pending = 1'b1;
            opstart             = 1'b1;
         end
      end
      rsp.carrier_state  = mid.mode;
      rsp.send_set_attr  = set_attr;
      rsp.send_opstart   = opstart;
      rsp.event_rejected = rejected;
   end

endmodule

`default_nettype wire

// ===== rtl/core/radio_carrier_mo_state_machine_top.sv =====
// Radio carrier operational state machine: top level with input and result registers.
// Depends on rcms_pkg and rcms_event_logic.
//
// Each accepted event yields exactly one result item: the event sits in an input register,
// and the state and flag logic evaluates it and writes the carrier state and the result
// register together, so the next event sees the updated state. One event is taken every
// cycle while the result side is not stalled. The result register holds a finished item
// while a new event is accepted.
`default_nettype none

module radio_carrier_mo_state_machine_top (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  rcms_pkg::rcms_req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output rcms_pkg::rcms_rsp_type rsp_data
);
   import rcms_pkg::*;

   logic           in_valid_ff, in_valid_in;
   rcms_req_type   in_data_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rcms_rsp_type   rsp_data_ff;
   rcms_state_type state_ff;
   rcms_state_type state_nxt;
   rcms_rsp_type   rsp_nxt;
   logic           advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   rcms_event_logic u_event_logic (
      .req (in_data_ff),
      .cur (state_ff),
      .nxt (state_nxt),
      .rsp (rsp_nxt)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{mode: ST_NOT_INSTALLED, default: 1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_nxt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rcms_checker.sv =====
// Port-level checks for the radio carrier state machine, bound to the top level.
// Depends on rcms_pkg.
`default_nettype none

module rcms_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_ready,
   input rcms_pkg::rcms_req_type req_data,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input rcms_pkg::rcms_rsp_type rsp_data
);
   import rcms_pkg::*;

   // nothing comes out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_rejected |->
         !rsp_data.send_set_attr && !rsp_data.send_opstart &&
         rsp_data.adm_command == ADM_NONE)
      else $error("rejected event raised a command");

   // opstart is only ever issued from the offline state
   a_opstart_offline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.send_opstart |-> rsp_data.carrier_state == ST_OFFLINE)
      else $error("opstart outside offline");

   // a waiting input item keeps its valid and payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("waiting input item changed");

endmodule

bind radio_carrier_mo_state_machine_top rcms_checker u_rcms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== dv/tb_radio_carrier_mo_state_machine_top.sv =====
// Self-checking testbench for the radio carrier operational state machine.
// Depends on rcms_pkg and radio_carrier_mo_state_machine_top; drives events with random
// idle and stall phases and checks every result against a cycle-free state predictor or a fixed expected result.
`timescale 1ns / 1ps

module tb_radio_carrier_mo_state_machine_top;
   import rcms_pkg::*;

   localparam logic [2:0] EV_UNUSED   = 3'd7;
   localparam logic [2:0] AV_OTHER    = 3'd5;
   localparam logic [2:0] AV_CODE_MAX = 3'd7;

   localparam int RANDOM_ITEMS_PER_PHASE = 200;
   localparam int WATCHDOG_LIMIT         = 5000;
   localparam int DRAIN_CYCLES           = 10;
   localparam int MAX_REPORTED           = 10;

   typedef struct packed {
      rcms_req_type req;
      logic         typed;
      rcms_rsp_type rsp;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   rcms_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rcms_rsp_type rsp_data;

   // tracked copy of the carrier state and flags
   rcms_mode_type trk_mode;
   logic          trk_attr_sent;
   logic          trk_attr_acked;
   logic          trk_unlock_sent;
   logic          trk_opstart_pending;
   logic          trk_forced_lock;
   rcms_rsp_type  step_rsp;

   rcms_rsp_type pending_rsp_q[$];
   stim_row_type directed_rows[$];

   int error_count;
   int rsp_count;
   int idle_cycles;
   int idle_pct;
   int stall_pct;

   radio_carrier_mo_state_machine_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // configuration pass: admin bit and opstart permission
   function automatic void config_pass(input logic admin_unlocked, input logic allow_op);
      if (!trk_attr_sent && !trk_attr_acked) begin
         trk_attr_sent = 1'b1;
         step_rsp.send_set_attr = 1'b1;
      end
      if (!trk_forced_lock && !admin_unlocked && !trk_unlock_sent) begin
         trk_unlock_sent = 1'b1;
         step_rsp.adm_command = ADM_UNLOCK;
      end
      if (allow_op && admin_unlocked && trk_attr_acked && !trk_opstart_pending) begin
         trk_opstart_pending = 1'b1;
         step_rsp.send_opstart = 1'b1;
      end
   endfunction

   function automatic void enter_mode(input rcms_mode_type nxt, input logic stored_admin);
      trk_mode = nxt;
      case (nxt)
         ST_DEPENDENCY: config_pass(stored_admin, 1'b0);
         ST_OFFLINE:    config_pass(stored_admin, 1'b1);
         default: begin
            trk_attr_sent       = 1'b0;
            trk_attr_acked      = 1'b0;
            trk_unlock_sent     = 1'b0;
            trk_opstart_pending = 1'b0;
         end
      endcase
   endfunction

   function automatic rcms_rsp_type predict_carrier_rsp(input rcms_req_type ev);
      rcms_mode_type target;
      logic          moves;
      logic          rejected;
      step_rsp = '0;
      rejected = 1'b0;
      moves    = 1'b0;
      target   = trk_mode;
      case (ev.req_type)
         EV_SW_ACT_REP: rejected = (trk_mode != ST_NOT_INSTALLED);
         EV_STATE_REP: begin
            if (ev.rep_operational) begin
               if (trk_mode != ST_ENABLED) begin
                  moves  = 1'b1;
                  target = ST_ENABLED;
               end
            end else if (ev.rep_availability == AV_NOT_INSTALLED ||
                         ev.rep_availability == AV_POWER_OFF) begin
               moves  = 1'b1;
               target = ST_NOT_INSTALLED;
            end else if (ev.rep_availability == AV_DEPENDENCY) begin
               moves  = 1'b1;
               target = ST_DEPENDENCY;
            end else if (ev.rep_availability == AV_OFFLINE ||
                         ev.rep_availability == AV_OK) begin
               moves  = 1'b1;
               target = ST_OFFLINE;
            end
            if (moves) begin
               // same dependency/offline state: pass with the reported admin bit
               if (target == trk_mode) begin
                  if (target == ST_DEPENDENCY)
                     config_pass(ev.rep_admin_unlocked, 1'b0);
                  else if (target == ST_OFFLINE)
                     config_pass(ev.rep_admin_unlocked, 1'b1);
               end else begin
                  enter_mode(target, ev.stored_admin_unlocked);
               end
            end
         end
         EV_ATTR_ACK: begin
            if (trk_mode == ST_DEPENDENCY || trk_mode == ST_OFFLINE) begin
               trk_attr_acked = 1'b1;
               trk_attr_sent  = 1'b0;
               config_pass(ev.stored_admin_unlocked, trk_mode == ST_OFFLINE);
            end else begin
               rejected = 1'b1;
            end
         end
         EV_OPSTART_ACK, EV_OPSTART_NAK: trk_opstart_pending = 1'b0;
         EV_FORCE_LOCK: begin
            trk_forced_lock      = ev.lock_request;
            step_rsp.adm_command = ev.lock_request ? ADM_LOCK : ADM_UNLOCK;
         end
         EV_LINK_DOWN: begin
            if (trk_mode != ST_NOT_INSTALLED)
               enter_mode(ST_NOT_INSTALLED, ev.stored_admin_unlocked);
         end
         default: rejected = 1'b1;
      endcase
      step_rsp.carrier_state  = trk_mode;
      step_rsp.event_rejected = rejected;
      return step_rsp;
   endfunction

   function automatic rcms_req_type make_req(input logic [2:0] ev, input logic op,
                                             input logic [2:0] av, input logic ra,
                                             input logic sa, input logic lk);
      rcms_req_type r;
      r.req_type              = ev;
      r.rep_operational       = op;
      r.rep_availability      = av;
      r.rep_admin_unlocked    = ra;
      r.stored_admin_unlocked = sa;
      r.lock_request          = lk;
      return r;
   endfunction

   task automatic add_row(input rcms_req_type req, input logic typed, input rcms_rsp_type rsp);
      stim_row_type row;
      row.req   = req;
      row.typed = typed;
      row.rsp   = rsp;
      directed_rows.push_back(row);
   endtask

   // mostly state reports and acks so the machine walks through all states
   function automatic rcms_req_type random_carrier_req();
      rcms_req_type r;
      int unsigned  pick;
      pick = $urandom_range(99);
      if (pick < 40)      r.req_type = EV_STATE_REP;
      else if (pick < 60) r.req_type = EV_ATTR_ACK;
      else if (pick < 68) r.req_type = EV_OPSTART_ACK;
      else if (pick < 75) r.req_type = EV_OPSTART_NAK;
      else if (pick < 83) r.req_type = EV_FORCE_LOCK;
      else if (pick < 90) r.req_type = EV_LINK_DOWN;
      else if (pick < 95) r.req_type = EV_SW_ACT_REP;
      else                r.req_type = EV_UNUSED;
      r.rep_operational = ($urandom_range(99) < 20);
      if ($urandom_range(9) == 0)
         r.rep_availability = 3'($urandom_range(AV_OTHER, AV_CODE_MAX));
      else
         r.rep_availability = 3'($urandom_range(AV_NOT_INSTALLED, AV_OK));
      r.rep_admin_unlocked    = 1'($urandom_range(1));
      r.stored_admin_unlocked = 1'($urandom_range(1));
      r.lock_request          = 1'($urandom_range(1));
      return r;
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTED)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   // called at a falling edge; returns at a falling edge with valid still high
   task automatic send_item(input rcms_req_type item, input logic typed,
                            input rcms_rsp_type typed_rsp);
      rcms_rsp_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_carrier_rsp(item);
      pending_rsp_q.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (pending_rsp_q.size() != 0) @(negedge clock);
   endtask

   // result checker
   always @(posedge clock) begin : rsp_check
      rcms_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (pending_rsp_q.size() == 0) begin
            flag_error($sformatf("result %0d with no event outstanding", rsp_count));
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.carrier_state !== want.carrier_state ||
                rsp_data.send_set_attr !== want.send_set_attr ||
                rsp_data.adm_command !== want.adm_command ||
                rsp_data.send_opstart !== want.send_opstart ||
                rsp_data.event_rejected !== want.event_rejected)
               flag_error($sformatf(
                  "result %0d: exp st=%0d attr=%0d adm=%0d op=%0d rej=%0d, got st=%0d attr=%0d adm=%0d op=%0d rej=%0d",
                  rsp_count, want.carrier_state, want.send_set_attr, want.adm_command,
                  want.send_opstart, want.event_rejected, rsp_data.carrier_state,
                  rsp_data.send_set_attr, rsp_data.adm_command, rsp_data.send_opstart,
                  rsp_data.event_rejected));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      error_count = 0;
      rsp_count   = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      trk_mode            = ST_NOT_INSTALLED;
      trk_attr_sent       = 1'b0;
      trk_attr_acked      = 1'b0;
      trk_unlock_sent     = 1'b0;
      trk_opstart_pending = 1'b0;
      trk_forced_lock     = 1'b0;

      add_row(make_req(EV_SW_ACT_REP, 0, AV_NOT_INSTALLED, 0, 0, 0), 1,
              {ST_NOT_INSTALLED, 1'b0, ADM_NONE, 1'b0, 1'b0});
      add_row(make_req(EV_ATTR_ACK, 0, AV_NOT_INSTALLED, 0, 0, 0), 1,
              {ST_NOT_INSTALLED, 1'b0, ADM_NONE, 1'b0, 1'b1});
      add_row(make_req(EV_UNUSED, 0, AV_NOT_INSTALLED, 0, 0, 0), 1,
              {ST_NOT_INSTALLED, 1'b0, ADM_NONE, 1'b0, 1'b1});
      add_row(make_req(EV_STATE_REP, 0, AV_NOT_INSTALLED, 0, 0, 0), 1,
              {ST_NOT_INSTALLED, 1'b0, ADM_NONE, 1'b0, 1'b0});
      add_row(make_req(EV_STATE_REP, 0, AV_OTHER, 1, 1, 0), 0, '0);
      add_row(make_req(EV_STATE_REP, 0, AV_DEPENDENCY, 0, 0, 0), 1,
              {ST_DEPENDENCY, 1'b1, ADM_UNLOCK, 1'b0, 1'b0});
      add_row(make_req(EV_STATE_REP, 0, AV_DEPENDENCY, 1, 0, 0), 0, '0);
      add_row(make_req(EV_ATTR_ACK, 0, AV_NOT_INSTALLED, 0, 1, 0), 0, '0);
      add_row(make_req(EV_STATE_REP, 0, AV_OFFLINE, 0, 1, 0), 0, '0);
      add_row(make_req(EV_OPSTART_ACK, 0, AV_NOT_INSTALLED, 0, 0, 0), 0, '0);
      add_row(make_req(EV_STATE_REP, 0, AV_OK, 1, 0, 0), 0, '0);
      add_row(make_req(EV_OPSTART_NAK, 0, AV_NOT_INSTALLED, 0, 0, 0), 0, '0);
      add_row(make_req(EV_FORCE_LOCK, 0, AV_NOT_INSTALLED, 0, 0, 1), 1,
              {ST_OFFLINE, 1'b0, ADM_LOCK, 1'b0, 1'b0});
      add_row(make_req(EV_STATE_REP, 1, AV_OK, 1, 1, 0), 0, '0);
      add_row(make_req(EV_SW_ACT_REP, 0, AV_NOT_INSTALLED, 0, 0, 0), 1,
              {ST_ENABLED, 1'b0, ADM_NONE, 1'b0, 1'b1});
      add_row(make_req(EV_ATTR_ACK, 0, AV_NOT_INSTALLED, 0, 0, 0), 1,
              {ST_ENABLED, 1'b0, ADM_NONE, 1'b0, 1'b1});
      add_row(make_req(EV_STATE_REP, 1, AV_DEPENDENCY, 0, 0, 0), 0, '0);
      add_row(make_req(EV_STATE_REP, 0, AV_POWER_OFF, 0, 0, 0), 0, '0);
      // forced lock still set: offline entry sends attributes but no unlock
      add_row(make_req(EV_STATE_REP, 0, AV_OFFLINE, 0, 0, 0), 0, '0);
      add_row(make_req(EV_FORCE_LOCK, 0, AV_NOT_INSTALLED, 0, 0, 0), 0, '0);
      add_row(make_req(EV_LINK_DOWN, 0, AV_NOT_INSTALLED, 0, 0, 0), 0, '0);
      add_row(make_req(EV_LINK_DOWN, 0, AV_NOT_INSTALLED, 0, 0, 0), 1,
              {ST_NOT_INSTALLED, 1'b0, ADM_NONE, 1'b0, 1'b0});
      add_row(make_req(EV_STATE_REP, 0, AV_CODE_MAX, 0, 0, 0), 0, '0);
      add_row(make_req(EV_UNUSED, 1, AV_CODE_MAX, 1, 1, 1), 1,
              {ST_NOT_INSTALLED, 1'b0, ADM_NONE, 1'b0, 1'b1});

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      wait_for_drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 72; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 72; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++)
            send_item(random_carrier_req(), 1'b0, '0);
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp_q.size() != 0)
         flag_error($sformatf("%0d results never arrived", pending_rsp_q.size()));
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
